// ----- rtl/core/lra_pkg.sv -----
// ----------------------------------------------------------------------------
// lra_pkg - shared types for the line rasteriser
// Command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package lra_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the endpoints of an accepted line
        logic setup;  // swap, order and seed the error term
        logic step;   // advance one pixel along the major axis
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;   // current pixel is the final one of the line
    } t_dp_sts;

endpackage

// ----- rtl/core/lra_if.sv -----
// ----------------------------------------------------------------------------
// lra_if - valid/ready channels of the line rasteriser
// Line channel carries two endpoints; pixel channel carries one pixel.
// ----------------------------------------------------------------------------
interface lra_line_if #(
    parameter int COORD_BITS = 6
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

interface lra_pixel_if #(
    parameter int COORD_BITS = 6
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input last_pixel, output ready);
endinterface

// ----- rtl/core/lra_ctrl.sv -----
// ----------------------------------------------------------------------------
// lra_ctrl - line rasteriser controller
// Sequences accept, setup and per-pixel emission; drives the handshakes.
// ----------------------------------------------------------------------------
module lra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  lra_pkg::t_dp_sts i_sts,
    output lra_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    logic in_acc;
    logic out_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    assign o_cmd.load  = in_acc;
    assign o_cmd.setup = (r_state == ST_SETUP);
    assign o_cmd.step  = out_acc && !i_sts.last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // drop back to idle once the final pixel is taken
                if (out_acc && i_sts.last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/lra_dp.sv -----
// ----------------------------------------------------------------------------
// lra_dp - line rasteriser datapath
// Holds endpoints, spans, error term and the current pixel position.
// ----------------------------------------------------------------------------
module lra_dp #(
    parameter int COORD_BITS = 6
) (
    input  logic                         i_clk,
    input  lra_pkg::t_dp_cmd             i_cmd,
    output lra_pkg::t_dp_sts             o_sts,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y
);

    localparam int DW = COORD_BITS + 1;  // difference of two coordinates
    localparam int EW = COORD_BITS + 2;  // error term, spans both signs

    // captured endpoints
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;

    // walk state
    logic signed [COORD_BITS-1:0] r_major, n_major;
    logic signed [COORD_BITS-1:0] r_minor, n_minor;
    logic signed [COORD_BITS-1:0] r_end, n_end;
    logic signed [DW-1:0]         r_dmaj, n_dmaj;
    logic signed [DW-1:0]         r_dmin, n_dmin;
    logic signed [EW-1:0]         r_err, n_err;
    logic                         r_steep, n_steep;
    logic                         r_down, n_down;

    // setup terms
    logic signed [DW-1:0]         dx, dy, adx, ady, dmn;
    logic signed [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
    logic signed [COORD_BITS-1:0] lo_maj, lo_min, hi_maj, hi_min;
    logic                         steep, swap;
    logic signed [EW-1:0]         err_sub;

    always_comb begin
        dx    = DW'(r_bx) - DW'(r_ax);
        dy    = DW'(r_by) - DW'(r_ay);
        adx   = (dx < 0) ? -dx : dx;
        ady   = (dy < 0) ? -dy : dy;
        steep = (ady > adx);

        a_maj = steep ? r_ay : r_ax;
        a_min = steep ? r_ax : r_ay;
        b_maj = steep ? r_by : r_bx;
        b_min = steep ? r_bx : r_by;

        // equal major coordinates keep the start endpoint first
        swap   = (a_maj > b_maj);
        lo_maj = swap ? b_maj : a_maj;
        lo_min = swap ? b_min : a_min;
        hi_maj = swap ? a_maj : b_maj;
        hi_min = swap ? a_min : b_min;
        dmn    = DW'(hi_min) - DW'(lo_min);

        err_sub = r_err - EW'(r_dmin);

        n_major = r_major;
        n_minor = r_minor;
        n_end   = r_end;
        n_dmaj  = r_dmaj;
        n_dmin  = r_dmin;
        n_err   = r_err;
        n_steep = r_steep;
        n_down  = r_down;

        if (i_cmd.setup) begin
            n_steep = steep;
            n_major = lo_maj;
            n_minor = lo_min;
            n_end   = hi_maj;
            n_dmaj  = DW'(hi_maj) - DW'(lo_maj);
            n_dmin  = (dmn < 0) ? -dmn : dmn;
            n_down  = (lo_min >= hi_min);
            n_err   = EW'(n_dmaj >>> 1);
        end else if (i_cmd.step) begin
            n_major = r_major + COORD_BITS'(1);
            n_err   = err_sub;
            if (err_sub < 0) begin
                n_err   = err_sub + EW'(r_dmaj);
                n_minor = r_down ? (r_minor - COORD_BITS'(1))
                                 : (r_minor + COORD_BITS'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_start_x;
            r_ay <= i_start_y;
            r_bx <= i_end_x;
            r_by <= i_end_y;
        end
        r_major <= n_major;
        r_minor <= n_minor;
        r_end   <= n_end;
        r_dmaj  <= n_dmaj;
        r_dmin  <= n_dmin;
        r_err   <= n_err;
        r_steep <= n_steep;
        r_down  <= n_down;
    end

    assign o_sts.last = (r_major == r_end);
    assign o_pixel_x  = r_steep ? r_minor : r_major;
    assign o_pixel_y  = r_steep ? r_major : r_minor;

endmodule

// ----- rtl/core/line_rasterizer_all_octants.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_all_octants - Bresenham line walk over all octants
// Takes a line segment and emits every pixel on it, the last one flagged.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries                              Per transaction
//  i_line    sink       start_x, start_y, end_x, end_y       one line segment
//  o_pixel   source     pixel_x, pixel_y, last_pixel         one pixel
//
//  A line of major span N is accepted, then set up (steep swap, endpoint
//  ordering, spans and error seed), then emitted as N + 1 pixels at one
//  per cycle while the pixel side does not stall, set by the single
//  error-term update done per major step.
//  Only one line is in flight; i_line.ready is high while idle.
//  Reset is synchronous and active low; it returns the controller to idle.
//  A stall on o_pixel holds the current pixel and freezes the walk.
//
module line_rasterizer_all_octants #(
    parameter int COORD_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lra_line_if.sink    i_line,
    lra_pixel_if.source o_pixel
);

    lra_pkg::t_dp_cmd cmd;
    lra_pkg::t_dp_sts sts;

    // Controller: owns the handshakes and tells the datapath when to
    // capture a transaction, seed the walk and advance one pixel.
    lra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_pixel.valid),
        .i_out_ready (o_pixel.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: endpoint registers, spans, error term and the pixel
    // position, mapped back to the original x/y orientation at the output.
    lra_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_start_x (i_line.start_x),
        .i_start_y (i_line.start_y),
        .i_end_x   (i_line.end_x),
        .i_end_y   (i_line.end_y),
        .o_pixel_x (o_pixel.pixel_x),
        .o_pixel_y (o_pixel.pixel_y)
    );

    // Flag the final pixel straight from the datapath status
    assign o_pixel.last_pixel = sts.last;

endmodule

// ----- rtl/core/lra_checker.sv -----
// ----------------------------------------------------------------------------
// lra_checker - port-level checks for the line rasteriser
// Watches both channels and checks the per-line sequencing over time.
// ----------------------------------------------------------------------------
module lra_checker #(
    parameter int COORD_BITS = 6
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [COORD_BITS-1:0] i_pixel_x,
    input logic signed [COORD_BITS-1:0] i_pixel_y,
    input logic                         i_last_pixel
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // one line at a time: never take a line while pixels are on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("line accepted while a pixel is pending");

    // the setup cycle follows every accepted line
    a_setup_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_out_valid && !i_in_ready)
        else $error("no setup cycle after line transaction");

    // the final pixel frees the block for the next line
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && i_last_pixel |=> i_in_ready)
        else $error("block not idle after final pixel");

    // a line never ends early
    a_walk_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_last_pixel |=> i_out_valid)
        else $error("pixel stream broke before final pixel");

    // a stalled pixel holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_x) && $stable(i_pixel_y)
            && $stable(i_last_pixel))
        else $error("stalled pixel changed");

endmodule

bind line_rasterizer_all_octants lra_checker #(
    .COORD_BITS (COORD_BITS)
) u_lra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_line.valid),
    .i_in_ready   (i_line.ready),
    .i_out_valid  (o_pixel.valid),
    .i_out_ready  (o_pixel.ready),
    .i_pixel_x    (o_pixel.pixel_x),
    .i_pixel_y    (o_pixel.pixel_y),
    .i_last_pixel (o_pixel.last_pixel)
);
